FILE: hw/rtl/lis_pkg.sv
// shared types and constants of the longest increasing subsequence block
`timescale 1ns / 1ps
package lis_pkg;

  localparam int unsigned ValW    = 32;
  localparam int unsigned LenOutW = 7;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   last_item;
  } in_beat_t;

  typedef struct packed {
    logic [LenOutW-1:0]     seq_length;
    logic signed [ValW-1:0] element;
    logic                   overflow;
    logic                   last_result;
  } out_beat_t;

endpackage

FILE: hw/rtl/lis_in_if.sv
// input channel: one sequence element per beat
`timescale 1ns / 1ps
interface lis_in_if;
  logic              valid;
  logic              ready;
  lis_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/lis_out_if.sv
// output channel: one subsequence element per beat
`timescale 1ns / 1ps
interface lis_out_if;
  logic               valid;
  logic               ready;
  lis_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/longest_increasing_subsequence_top.sv
// top level: load, run length fill and trace back of the longest increasing subsequence
// load: one beat per cycle, n beats until the one marked last
// fill: each position is compared with every later position, bound by the one read port of the run length ram
// trace: each scanned position passes S_TR_RD then S_TR_CMP, one output beat per element
// next sequence loads once the last element is in the output register
// reset: control cleared asynchronously, rams hold no reset value and are not swept
`timescale 1ns / 1ps
module longest_increasing_subsequence_top #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lis_in_if.sink     in_i,
  lis_out_if.source  out_o
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ITEMS);

  typedef enum logic [5:0] {
    S_LOAD   = 6'b000001,
    S_HEAD   = 6'b000010,
    S_PIVOT  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_TR_RD  = 6'b010000,
    S_TR_CMP = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] p_q, p_d;
  logic [CW-1:0] j_q, j_d;
  logic          vld_q, vld_d;
  logic [lis_pkg::ValW-1:0] vp_q, vp_d;
  logic [CW-1:0] best_q, best_d;
  logic [CW-1:0] len_q, len_d;
  logic [IW-1:0] start_q, start_d;
  logic [IW-1:0] k_q, k_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          first_q, first_d;
  logic          out_vld_q, out_vld_d;
  lis_pkg::out_beat_t out_q, out_d;

  logic [IW-1:0] rd_addr;
  logic          v_we;
  logic [lis_pkg::ValW-1:0] v_rdata;
  logic          r_we;
  logic [CW-1:0] r_wdata;
  logic [CW-1:0] r_rdata;
  logic          emit;
  logic          can_emit;
  logic          match;
  logic [CW-1:0] next_j;
  logic [CW-1:0] run_new;

  lis_ram #(
    .WIDTH (lis_pkg::ValW),
    .DEPTH (MAX_ITEMS)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (in_i.data.value),
    .raddr_i (rd_addr),
    .rdata_o (v_rdata)
  );

  lis_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_ITEMS)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (p_q),
    .wdata_i (r_wdata),
    .raddr_i (rd_addr),
    .rdata_o (r_rdata)
  );

  assign can_emit = !out_vld_q || out_o.ready;
  assign next_j   = CW'(p_q) + 1'b1;
  assign run_new  = best_q + 1'b1;
  assign r_wdata  = run_new;
  assign match    = first_q ||
                    ((r_rdata == rem_q) && ($signed(vp_q) < $signed(v_rdata)));

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    p_d      = p_q;
    j_d      = j_q;
    vld_d    = vld_q;
    vp_d     = vp_q;
    best_d   = best_q;
    len_d    = len_q;
    start_d  = start_q;
    k_d      = k_q;
    rem_d    = rem_q;
    first_d  = first_q;
    rd_addr  = k_q;
    v_we     = 1'b0;
    r_we     = 1'b0;
    emit     = 1'b0;
    in_i.ready = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (cnt_q < MaxCnt) begin
            v_we  = 1'b1;
            cnt_d = cnt_q + 1'b1;
            p_d   = cnt_q[IW-1:0];
          end else begin
            ovf_d = 1'b1;
            p_d   = IW'(MAX_ITEMS - 1);
          end
          if (in_i.data.last_item) begin
            len_d   = '0;
            state_d = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        rd_addr = p_q;
        state_d = S_PIVOT;
      end
      S_PIVOT: begin
        vp_d   = v_rdata;
        best_d = '0;
        if (next_j < cnt_q) begin
          rd_addr = next_j[IW-1:0];
          vld_d   = 1'b1;
          j_d     = next_j + 1'b1;
        end else begin
          vld_d = 1'b0;
        end
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (vld_q && ($signed(vp_q) < $signed(v_rdata)) && (r_rdata > best_q)) begin
          best_d = r_rdata;
        end
        if (j_q < cnt_q) begin
          rd_addr = j_q[IW-1:0];
          j_d     = j_q + 1'b1;
          vld_d   = 1'b1;
        end else begin
          vld_d = 1'b0;
        end
        if (!vld_q) begin
          r_we = 1'b1;
          if (run_new >= len_q) begin
            len_d   = run_new;
            start_d = p_q;
          end
          if (p_q == '0) begin
            k_d     = (run_new >= len_q) ? p_q : start_q;
            rem_d   = (run_new >= len_q) ? run_new : len_q;
            first_d = 1'b1;
            state_d = S_TR_RD;
          end else begin
            p_d     = p_q - 1'b1;
            state_d = S_HEAD;
          end
        end
      end
      S_TR_RD: begin
        state_d = S_TR_CMP;
      end
      S_TR_CMP: begin
        if (match) begin
          if (can_emit) begin
            emit    = 1'b1;
            vp_d    = v_rdata;
            rem_d   = rem_q - 1'b1;
            first_d = 1'b0;
            if (rem_q == CW'(1)) begin
              cnt_d   = '0;
              ovf_d   = 1'b0;
              state_d = S_LOAD;
            end else begin
              k_d     = k_q + 1'b1;
              state_d = S_TR_RD;
            end
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_TR_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_o.ready;
    if (emit) begin
      out_vld_d         = 1'b1;
      out_d.seq_length  = lis_pkg::LenOutW'(len_q);
      out_d.element     = v_rdata;
      out_d.overflow    = ovf_q;
      out_d.last_result = (rem_q == CW'(1));
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      vld_q     <= 1'b0;
      first_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      vld_q     <= vld_d;
      first_q   <= first_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    j_q     <= j_d;
    vp_q    <= vp_d;
    best_q  <= best_d;
    len_q   <= len_d;
    start_q <= start_d;
    k_q     <= k_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
  end

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_we |-> (r_wdata <= cnt_q))
    else $error("run length exceeds item count");

  a_trace_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TR_CMP) |-> (CW'(k_q) < cnt_q))
    else $error("trace index beyond loaded items");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == MaxCnt))
    else $error("overflow set with store not full");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (rem_q == CW'(1))) |=> ((state_q == S_LOAD) && (cnt_q == '0)))
    else $error("last element did not return to load");

endmodule

FILE: hw/rtl/lis_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
